FILE: src/vfhp_pkg.sv
// Package for the voice file header parser.
// Holds the result record, result codes, parser modes and the signature table.
// No dependencies.
package vfhp_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_SIGNATURE = 3'd0,
    ERR_VERSION   = 3'd1,
    ERR_BLOCKTYPE = 3'd2,
    ERR_SIZE      = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  // Parser modes, one-hot.
  typedef enum logic [2:0] {
    MODE_HEADER  = 3'b001,
    MODE_PAYLOAD = 3'b010,
    MODE_DISCARD = 3'b100
  } mode_t;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    err_t        error_code;
    logic [7:0]  rate_code;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [7:0]  sample_format;
    logic [23:0] payload_length;
  } result_t;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Header layout.
  localparam logic [4:0]  SIG_LEN     = 5'd20;
  localparam logic [4:0]  IDX_SIG_END = 5'd19;
  localparam logic [4:0]  IDX_VER_LO  = 5'd22;
  localparam logic [4:0]  IDX_VER_HI  = 5'd23;
  localparam logic [4:0]  IDX_CHK_LO  = 5'd24;
  localparam logic [4:0]  IDX_CHK_HI  = 5'd25;
  localparam logic [4:0]  IDX_TYPE    = 5'd26;
  localparam logic [4:0]  IDX_SIZE0   = 5'd27;
  localparam logic [4:0]  IDX_SIZE1   = 5'd28;
  localparam logic [4:0]  IDX_SIZE2   = 5'd29;
  localparam logic [4:0]  IDX_RATE    = 5'd30;
  localparam logic [4:0]  IDX_FORMAT  = 5'd31;

  localparam logic [15:0] CHECK_BASE  = 16'h1234;
  localparam logic [7:0]  BLOCK_SOUND = 8'd1;
  localparam logic [23:0] MIN_SIZE    = 24'd2;

  // Expected signature byte at each of the first twenty header positions.
  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h43;
      5'd1:    b = 8'h72;
      5'd2:    b = 8'h65;
      5'd3:    b = 8'h61;
      5'd4:    b = 8'h74;
      5'd5:    b = 8'h69;
      5'd6:    b = 8'h76;
      5'd7:    b = 8'h65;
      5'd8:    b = 8'h20;
      5'd9:    b = 8'h56;
      5'd10:   b = 8'h6F;
      5'd11:   b = 8'h69;
      5'd12:   b = 8'h63;
      5'd13:   b = 8'h65;
      5'd14:   b = 8'h20;
      5'd15:   b = 8'h46;
      5'd16:   b = 8'h69;
      5'd17:   b = 8'h6C;
      5'd18:   b = 8'h65;
      5'd19:   b = 8'h1A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/vfhp_front.sv
// Front end of the voice file header parser: takes one byte per cycle when
// accept is high, walks the header, streams payload bytes, forms result items.
// Depends on vfhp_pkg.
module vfhp_front import vfhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       file_end,
  output logic       res_valid,
  output result_t    res
);

  mode_t       mode_r, mode_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        sig_bad_r, sig_bad_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [7:0]  chk_lo_r, chk_lo_nxt;
  logic [23:0] size_r, size_nxt;
  logic [23:0] remain_r, remain_nxt;
  logic [7:0]  rate_r, rate_nxt;

  // Per-byte parse step.
  always_comb begin
    logic        taken;
    logic [15:0] want;
    logic [23:0] plen;
    mode_nxt    = mode_r;
    idx_nxt     = idx_r;
    sig_bad_nxt = sig_bad_r;
    ver_nxt     = ver_r;
    chk_lo_nxt  = chk_lo_r;
    size_nxt    = size_r;
    remain_nxt  = remain_r;
    rate_nxt    = rate_r;
    res_valid   = 1'b0;
    res         = '0;
    taken       = 1'b0;
    want        = CHECK_BASE + ~ver_r;
    plen        = size_r - MIN_SIZE;

    if (accept) begin
      case (mode_r)
        MODE_PAYLOAD: begin
          res_valid = 1'b1;
          if (remain_r <= 24'd1) begin
            // Final payload byte: close the file or discard the tail.
            res.payload_byte = byte_value;
            res.last_payload = 1'b1;
            remain_nxt       = '0;
            mode_nxt         = file_end ? MODE_HEADER : MODE_DISCARD;
          end else if (file_end) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            mode_nxt       = MODE_HEADER;
          end else begin
            res.payload_byte = byte_value;
            remain_nxt       = remain_r - 24'd1;
          end
        end

        MODE_HEADER: begin
          // Header fields by position; taken marks a byte that ended the step.
          if (idx_r < SIG_LEN) begin
            if (byte_value != sig_byte(idx_r)) begin
              sig_bad_nxt = 1'b1;
            end
            if (idx_r == IDX_SIG_END && sig_bad_nxt) begin
              taken          = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SIGNATURE;
            end
          end else if (idx_r == IDX_VER_LO) begin
            ver_nxt = {8'h00, byte_value};
          end else if (idx_r == IDX_VER_HI) begin
            ver_nxt = {byte_value, ver_r[7:0]};
          end else if (idx_r == IDX_CHK_LO) begin
            chk_lo_nxt = byte_value;
          end else if (idx_r == IDX_CHK_HI) begin
            if ({byte_value, chk_lo_r} != want) begin
              taken          = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_VERSION;
            end
          end else if (idx_r == IDX_TYPE) begin
            if (byte_value != BLOCK_SOUND) begin
              taken          = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BLOCKTYPE;
            end
          end else if (idx_r == IDX_SIZE0) begin
            size_nxt = {16'h0000, byte_value};
          end else if (idx_r == IDX_SIZE1) begin
            size_nxt = {8'h00, byte_value, size_r[7:0]};
          end else if (idx_r == IDX_SIZE2) begin
            size_nxt = {byte_value, size_r[15:0]};
          end else if (idx_r == IDX_RATE) begin
            rate_nxt = byte_value;
          end else if (idx_r == IDX_FORMAT) begin
            taken     = 1'b1;
            res_valid = 1'b1;
            if (size_r < MIN_SIZE) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SIZE;
            end else if (plen != '0 && file_end) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TRUNCATED;
            end else begin
              res.kind           = KIND_HEADER;
              res.last_payload   = (plen == '0);
              res.rate_code      = rate_r;
              res.version_major  = ver_r[15:8];
              res.version_minor  = ver_r[7:0];
              res.sample_format  = byte_value;
              res.payload_length = plen;
            end
          end

          if (taken) begin
            // A header step that produced a result ends the header.
            if (file_end) begin
              mode_nxt = MODE_HEADER;
            end else if (res.kind == KIND_HEADER && plen != '0) begin
              mode_nxt   = MODE_PAYLOAD;
              remain_nxt = plen;
            end else begin
              mode_nxt = MODE_DISCARD;
            end
          end else if (file_end) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
            mode_nxt       = MODE_HEADER;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end

        default: begin
          // Discard until the file's final byte.
          if (file_end) begin
            mode_nxt = MODE_HEADER;
          end
        end
      endcase

      // Any step that lands in header mode on the final byte starts a new file.
      if (file_end) begin
        idx_nxt     = '0;
        sig_bad_nxt = 1'b0;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HEADER;
      idx_r     <= '0;
      sig_bad_r <= 1'b0;
      remain_r  <= '0;
    end else begin
      mode_r    <= mode_nxt;
      idx_r     <= idx_nxt;
      sig_bad_r <= sig_bad_nxt;
      remain_r  <= remain_nxt;
    end
  end

  // Header fields, always written before they are used.
  always_ff @(posedge clk) begin
    ver_r    <= ver_nxt;
    chk_lo_r <= chk_lo_nxt;
    size_r   <= size_nxt;
    rate_r   <= rate_nxt;
  end

`ifndef NO_ASSERTIONS
  // Payload mode always has at least one byte left to stream.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PAYLOAD |-> remain_r != '0)
    else $error("payload mode with no remaining bytes");

  // A file's final byte always returns the parser to the start of a header.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && file_end |=> mode_r == MODE_HEADER && idx_r == '0 && !sig_bad_r)
    else $error("file end did not restart the parser");

  // A header result marks last exactly when the payload is empty.
  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_HEADER |->
      res.last_payload == (res.payload_length == '0))
    else $error("header last mark disagrees with payload length");
`endif

endmodule

FILE: src/vfhp_queue.sv
// Short result queue between the parser and the output stage.
// Four entries of result records, one push and one pop per cycle.
// Depends on vfhp_pkg.
module vfhp_queue import vfhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_en,
  input  result_t push_data,
  input  logic    pop_en,
  output result_t head,
  output logic    q_empty,
  output logic    q_full
);

  result_t           mem [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]      count_r, count_nxt;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == (QAW+1)'(QDEPTH));
  assign head    = mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push_en) - (QAW+1)'(pop_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  // No item is written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !q_full)
    else $error("push into full result queue");

  // No item is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> !q_empty)
    else $error("pop from empty result queue");

  // The fill count matches the pointer distance.
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[QAW-1:0] == QAW'(wr_ptr_r - rd_ptr_r))
    else $error("result queue count disagrees with pointers");
`endif

endmodule

FILE: src/vfhp_back.sv
// Output stage of the voice file header parser: holds the oldest result
// item on the ports and refills from the result queue.
// Depends on vfhp_pkg.
module vfhp_back import vfhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  result_t q_head,
  output logic    q_pop,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Refill whenever the held item is absent or leaves this cycle.
  always_comb begin
    q_pop     = !q_empty && (!valid_r || pop);
    valid_nxt = q_pop || (valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_head;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: src/voice_file_header_parser_core.sv
// Top level of the voice file header parser.
// Instantiates vfhp_front, vfhp_queue and vfhp_back; depends on vfhp_pkg.
//
//   Channel   Ports                               Handshake
//   input     in_byte_value, in_file_end          push / full
//   result    out_kind .. out_payload_length      empty / pop
//
// One input item is taken per cycle while full is low; each yields at
// most one result item. A result passes through the four-entry result
// queue and then the output register before it reaches the ports.
// full rises when the result queue holds four items; it clears as the
// output stage drains the queue. Synchronous reset returns the parser
// to the start of a file header.
module voice_file_header_parser_core import vfhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_value,
  input  logic        in_file_end,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_rate_code,
  output logic [7:0]  out_version_major,
  output logic [7:0]  out_version_minor,
  output logic [7:0]  out_sample_format,
  output logic [23:0] out_payload_length
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t q_head;
  logic    q_empty;
  logic    q_full;
  logic    q_pop;
  logic    out_valid;
  result_t out_data;

  // Input handshake.
  assign full   = q_full;
  assign accept = push && !q_full;

  vfhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .file_end   (in_file_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  vfhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (res_valid),
    .push_data (res),
    .pop_en    (q_pop),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_full    (q_full)
  );

  vfhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .pop       (pop && out_valid),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Result ports.
  assign empty              = !out_valid;
  assign out_kind           = out_data.kind;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_last_payload   = out_data.last_payload;
  assign out_error_code     = out_data.error_code;
  assign out_rate_code      = out_data.rate_code;
  assign out_version_major  = out_data.version_major;
  assign out_version_minor  = out_data.version_minor;
  assign out_sample_format  = out_data.sample_format;
  assign out_payload_length = out_data.payload_length;

endmodule
